FILE: src/wcrc_pkg.sv
// ----------------------------------------------------------------------------
// wcrc_pkg
// Shared types, constants and byte-wise CRC update functions for the
// windowed multi-mode CRC unit.
// ----------------------------------------------------------------------------
package wcrc_pkg;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned CRC_W    = 32;
  localparam int unsigned IDX_W    = 8;

  localparam logic [1:0] MODE_CRC8  = 2'd0;
  localparam logic [1:0] MODE_CRC16 = 2'd1;
  localparam logic [1:0] MODE_CRC32 = 2'd2;

  localparam logic [IDX_W-1:0] REG_CRC_MODE     = 8'd0;
  localparam logic [IDX_W-1:0] REG_WINDOW_START = 8'd1;
  localparam logic [IDX_W-1:0] REG_WINDOW_END   = 8'd2;
  localparam logic [IDX_W-1:0] REG_RESERVED     = 8'd3;

  localparam logic [7:0]       POLY8    = 8'h07;
  localparam logic [15:0]      POLY16R  = 16'hA001;
  localparam logic [CRC_W-1:0] POLY32   = 32'h04C11DB7;
  localparam logic [CRC_W-1:0] ALL_ONES = 32'hFFFFFFFF;
  localparam logic [7:0]       INIT8    = 8'hFF;
  localparam logic [CRC_W-1:0] MSB32    = 32'h80000000;

  typedef struct packed {
    logic [1:0]        mode;
    logic [ADDR_W-1:0] win_start;
    logic [ADDR_W-1:0] win_end;
    logic [ADDR_W-1:0] rsv_addr;
  } wcrc_cfg_t;

  typedef struct packed {
    logic fire;
    logic incl;
    logic last;
    logic reload;
  } wcrc_ctrl_t;

  // mode code 3 behaves as CRC-32
  function automatic logic [1:0] eff_mode(logic [1:0] m);
    eff_mode = (m == MODE_CRC8 || m == MODE_CRC16) ? m : MODE_CRC32;
  endfunction

  function automatic logic [CRC_W-1:0] init_value(logic [1:0] m);
    logic [1:0] e;
    e = eff_mode(m);
    unique case (e)
      MODE_CRC8:  init_value = {24'd0, INIT8};
      MODE_CRC16: init_value = '0;
      default:    init_value = ALL_ONES;
    endcase
  endfunction

  function automatic logic [7:0] crc8_byte(logic [7:0] r, logic [7:0] d);
    logic [7:0] c;
    c = r ^ d;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ POLY8) : {c[6:0], 1'b0};
    end
    crc8_byte = c;
  endfunction

  function automatic logic [15:0] crc16_byte(logic [15:0] r, logic [7:0] d);
    logic [15:0] c;
    c = {8'd0, r[7:0] ^ d};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ({1'b0, c[15:1]} ^ POLY16R) : {1'b0, c[15:1]};
    end
    crc16_byte = {8'd0, r[15:8]} ^ c;
  endfunction

  function automatic logic [CRC_W-1:0] crc32_byte(logic [CRC_W-1:0] r, logic [7:0] d);
    logic [CRC_W-1:0] c;
    c = r ^ {d, 24'd0};
    for (int i = 0; i < 8; i++) begin
      c = ((c & MSB32) != '0) ? ({c[CRC_W-2:0], 1'b0} ^ POLY32) : {c[CRC_W-2:0], 1'b0};
    end
    crc32_byte = c;
  endfunction

endpackage

FILE: src/wcrc_window.sv
// ----------------------------------------------------------------------------
// wcrc_window
// Address filter: inclusive window test and reserved-region exclusion,
// region end computed one bit wider so it never wraps.
// ----------------------------------------------------------------------------
module wcrc_window
  import wcrc_pkg::*;
(
  input  logic [ADDR_W-1:0] addr_i,
  input  wcrc_cfg_t         cfg_i,
  output logic              incl_o
);

  logic [1:0]      mode;
  logic [2:0]      rlen;
  logic [ADDR_W:0] rend;
  logic            in_win;
  logic            in_rsv;

  always_comb begin
    mode = eff_mode(cfg_i.mode);
    unique case (mode)
      MODE_CRC8:  rlen = 3'd1;
      MODE_CRC16: rlen = 3'd2;
      default:    rlen = 3'd4;
    endcase
    rend   = {1'b0, cfg_i.rsv_addr} + {{(ADDR_W-2){1'b0}}, rlen};
    in_win = (addr_i >= cfg_i.win_start) && (addr_i <= cfg_i.win_end);
    in_rsv = (addr_i >= cfg_i.rsv_addr) && ({1'b0, addr_i} < rend);
    incl_o = in_win && !in_rsv;
  end

endmodule

FILE: src/wcrc_core.sv
// ----------------------------------------------------------------------------
// wcrc_core
// Running CRC register with one-byte update per word, finish and reload.
// ----------------------------------------------------------------------------
module wcrc_core
  import wcrc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       mode_i,
  input  logic [1:0]       load_mode_i,
  input  wcrc_ctrl_t       ctrl_i,
  input  logic [7:0]       data_i,
  output logic [CRC_W-1:0] result_o
);

  logic [CRC_W-1:0] crc_q, crc_d;
  logic [CRC_W-1:0] upd;
  logic [CRC_W-1:0] nxt;
  logic [1:0]       mode;

  always_comb begin
    mode = eff_mode(mode_i);
    unique case (mode)
      MODE_CRC8:  upd = {24'd0, crc8_byte(crc_q[7:0], data_i)};
      MODE_CRC16: upd = {16'd0, crc16_byte(crc_q[15:0], data_i)};
      default:    upd = crc32_byte(crc_q, data_i);
    endcase
    nxt = ctrl_i.incl ? upd : crc_q;
    unique case (mode)
      MODE_CRC8:  result_o = {24'd0, nxt[7:0]};
      MODE_CRC16: result_o = {16'd0, nxt[15:0]};
      default:    result_o = nxt ^ ALL_ONES;
    endcase
    // mode write: seed with the init value of the mode being written
    priority if (ctrl_i.reload) begin
      crc_d = init_value(load_mode_i);
    end else if (ctrl_i.fire) begin
      crc_d = ctrl_i.last ? init_value(mode_i) : nxt;
    end else begin
      crc_d = crc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= ALL_ONES;
    end else begin
      crc_q <= crc_d;
    end
  end

endmodule

FILE: src/windowed_multi_mode_crc_unit.sv
// ----------------------------------------------------------------------------
// windowed_multi_mode_crc_unit
// Windowed CRC-8 / CRC-16/ARC / CRC-32/BZIP2 over an addressed byte stream.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_stall_o | byte_address_i, data_byte_i, last_byte_i
//  out     | output    | out_valid_o / out_stall_i | crc_value_o
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  One word per cycle unless stalled; a last word's CRC loads as it leaves s1.
//  Path: input register, then filter + byte update into the result register.
//  Reset: mode CRC-32, full window, reserved region at top, CRC all ones.
//  in_stall_o rises only when a last word waits for a stalled result register.
//  cfg is always ready; a mode write reloads the CRC register.
// ----------------------------------------------------------------------------
module windowed_multi_mode_crc_unit
  import wcrc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [31:0]       byte_address_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [31:0]       crc_value_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]       cfg_data_i
);

  wcrc_cfg_t        cfg_q;
  logic             s1_valid_q;
  logic [ADDR_W-1:0] s1_addr_q;
  logic [7:0]       s1_data_q;
  logic             s1_last_q;
  logic             out_valid_q;
  logic [CRC_W-1:0] out_crc_q;
  logic             out_free;
  logic             s1_fire;
  logic             in_acc;
  logic             cfg_wr;
  logic             incl;
  logic [CRC_W-1:0] result;
  wcrc_ctrl_t       ctrl;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign s1_fire     = s1_valid_q && (!s1_last_q || out_free);
  assign in_stall_o  = s1_valid_q && !s1_fire;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign crc_value_o = out_crc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= MODE_CRC32;
      cfg_q.win_start <= '0;
      cfg_q.win_end   <= '1;
      cfg_q.rsv_addr  <= '1;
    end else if (cfg_wr) begin
      unique case (cfg_index_i)
        REG_CRC_MODE:     cfg_q.mode      <= cfg_data_i[1:0];
        REG_WINDOW_START: cfg_q.win_start <= cfg_data_i[ADDR_W-1:0];
        REG_WINDOW_END:   cfg_q.win_end   <= cfg_data_i[ADDR_W-1:0];
        REG_RESERVED:     cfg_q.rsv_addr  <= cfg_data_i[ADDR_W-1:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_addr_q <= byte_address_i[ADDR_W-1:0];
      s1_data_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_last_q) begin
      out_crc_q <= result;
    end
  end

  always_comb begin
    ctrl.fire   = s1_fire;
    ctrl.incl   = incl;
    ctrl.last   = s1_last_q;
    ctrl.reload = cfg_wr && (cfg_index_i == REG_CRC_MODE);
  end

  wcrc_window u_window (
    .addr_i (s1_addr_q),
    .cfg_i  (cfg_q),
    .incl_o (incl)
  );

  wcrc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (cfg_q.mode),
    .load_mode_i (cfg_data_i[1:0]),
    .ctrl_i      (ctrl),
    .data_i      (s1_data_q),
    .result_o    (result)
  );

`ifndef NO_ASSERTIONS
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s1_last_q)
    else $error("stall without a pending last word");

  a_last_makes_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_last_q) |=> out_valid_q)
    else $error("finished CRC not presented");

  a_blocked_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && s1_valid_q && s1_last_q) |-> in_stall_o && !s1_fire)
    else $error("last word advanced over a held result");
`endif

endmodule
